[hw/rtl/ucpd_pkg.sv]
package ucpd_pkg;

    // Field widths of the byte and result channels.
    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned LenW  = 3;

    // Sequence lengths, as carried in sequence_length and the open-sequence state.
    localparam logic [LenW-1:0] LenNone  = 3'd0;
    localparam logic [LenW-1:0] LenOne   = 3'd1;
    localparam logic [LenW-1:0] LenTwo   = 3'd2;
    localparam logic [LenW-1:0] LenThree = 3'd3;
    localparam logic [LenW-1:0] LenFour  = 3'd4;

    // Results caused by one byte: a run of error results for held bytes,
    // followed by at most one final result.
    typedef struct packed {
        logic [1:0]      err_cnt;
        logic            has_final;
        logic [CpW-1:0]  final_cp;
        logic            final_err;
        logic [LenW-1:0] final_len;
    } bundle_t;

endpackage

[hw/rtl/utf8_code_point_decoder_top.sv]
// UTF-8 code point decoder: one text byte per request, zero to four results.
// Each byte passes through the input register, is decoded, and its bundle is loaded into the
// result queue registers that present its results. Throughput: one byte per cycle while each
// byte gives at most one result and result_stall is low; a byte that gives several results
// stalls input until its last result is taken, as does result_stall holding back a result.
// Reset (rst_n, asynchronous, active low) empties both stages and closes any sequence.
module utf8_code_point_decoder_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        text_valid,
    output logic                        text_stall,
    input  logic [ucpd_pkg::ByteW-1:0]  text_byte,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [ucpd_pkg::CpW-1:0]    code_point,
    output logic                        is_error,
    output logic [ucpd_pkg::LenW-1:0]   sequence_length,
    output logic                        last_result
);

    logic                       in_valid_reg;
    logic [ucpd_pkg::ByteW-1:0] byte_reg;
    logic                       queue_ready;
    logic                       load;
    ucpd_pkg::bundle_t          bundle;

    // The held byte is decoded once the result queue can take its bundle.
    assign load       = in_valid_reg && queue_ready;
    assign text_stall = in_valid_reg && !queue_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            byte_reg <= text_byte;
        end
    end

    ucpd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .byte_in (byte_reg),
        .bundle  (bundle)
    );

    ucpd_result_queue u_queue
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .bundle          (bundle),
        .ready           (queue_ready),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .code_point      (code_point),
        .is_error        (is_error),
        .sequence_length (sequence_length),
        .last_result     (last_result)
    );

endmodule

[hw/rtl/ucpd_decode.sv]
module ucpd_decode
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [ucpd_pkg::ByteW-1:0]  byte_in,
    output ucpd_pkg::bundle_t           bundle
);

    logic [ucpd_pkg::CpW-1:0]  partial_reg;
    logic [ucpd_pkg::CpW-1:0]  partial_next;
    logic [ucpd_pkg::LenW-1:0] expected_reg;
    logic [ucpd_pkg::LenW-1:0] expected_next;
    logic [ucpd_pkg::LenW-1:0] held_reg;
    logic [ucpd_pkg::LenW-1:0] held_next;

    logic                      seq_open;
    logic                      is_cont;
    logic [ucpd_pkg::CpW-1:0]  partial_shift;
    logic [ucpd_pkg::LenW-1:0] held_inc;

    assign seq_open      = (expected_reg != ucpd_pkg::LenNone);
    assign is_cont       = (byte_in != 8'h00) && (byte_in[7:6] == 2'b10);
    assign partial_shift = {partial_reg[ucpd_pkg::CpW-7:0], byte_in[5:0]};
    assign held_inc      = held_reg + 3'd1;

    // Decode the byte against the open sequence and form the next state.
    always_comb
    begin
        partial_next       = partial_reg;
        expected_next      = expected_reg;
        held_next          = held_reg;
        bundle.err_cnt     = 2'd0;
        bundle.has_final   = 1'b0;
        bundle.final_cp    = '0;
        bundle.final_err   = 1'b0;
        bundle.final_len   = ucpd_pkg::LenOne;

        if (seq_open && is_cont)
        begin
            // A continuation byte extends the open sequence.
            if (held_inc >= expected_reg)
            begin
                bundle.has_final = 1'b1;
                bundle.final_cp  = partial_shift;
                bundle.final_len = expected_reg;
                partial_next     = '0;
                expected_next    = ucpd_pkg::LenNone;
                held_next        = 3'd0;
            end
            else
            begin
                partial_next = partial_shift;
                held_next    = held_inc;
            end
        end
        else
        begin
            // A broken sequence reports each held byte as an error, then
            // the current byte is handled with no sequence open.
            if (seq_open)
            begin
                bundle.err_cnt = held_reg[1:0];
            end
            partial_next  = '0;
            expected_next = ucpd_pkg::LenNone;
            held_next     = 3'd0;

            if (byte_in == 8'h00)
            begin
                // End of text gives no result of its own.
            end
            else if (byte_in[7] == 1'b0)
            begin
                bundle.has_final = 1'b1;
                bundle.final_cp  = {14'd0, byte_in[6:0]};
            end
            else if (byte_in[6] == 1'b0)
            begin
                bundle.has_final = 1'b1;
                bundle.final_err = 1'b1;
            end
            else if (byte_in[5] == 1'b0)
            begin
                partial_next  = {16'd0, byte_in[4:0]};
                expected_next = ucpd_pkg::LenTwo;
                held_next     = 3'd1;
            end
            else if (byte_in[4] == 1'b0)
            begin
                partial_next  = {17'd0, byte_in[3:0]};
                expected_next = ucpd_pkg::LenThree;
                held_next     = 3'd1;
            end
            else if (byte_in[3] == 1'b0)
            begin
                partial_next  = {18'd0, byte_in[2:0]};
                expected_next = ucpd_pkg::LenFour;
                held_next     = 3'd1;
            end
            else
            begin
                bundle.has_final = 1'b1;
                bundle.final_err = 1'b1;
            end
        end
    end

    // Sequence state advances only when the decoded byte is committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            expected_reg <= ucpd_pkg::LenNone;
            held_reg     <= 3'd0;
        end
        else if (load)
        begin
            partial_reg  <= partial_next;
            expected_reg <= expected_next;
            held_reg     <= held_next;
        end
    end

endmodule

[hw/rtl/ucpd_result_queue.sv]
module ucpd_result_queue
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ucpd_pkg::bundle_t           bundle,
    output logic                        ready,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [ucpd_pkg::CpW-1:0]    code_point,
    output logic                        is_error,
    output logic [ucpd_pkg::LenW-1:0]   sequence_length,
    output logic                        last_result
);

    logic [1:0]                err_left_reg;
    logic [1:0]                err_left_next;
    logic                      fin_left_reg;
    logic                      fin_left_next;
    logic [ucpd_pkg::CpW-1:0]  cp_reg;
    logic                      fin_err_reg;
    logic [ucpd_pkg::LenW-1:0] fin_len_reg;

    logic                      pop;
    logic                      in_errors;

    // The head result is an error for a held byte while any remain.
    assign in_errors       = (err_left_reg != 2'd0);
    assign result_valid    = in_errors || fin_left_reg;
    assign code_point      = in_errors ? '0 : cp_reg;
    assign is_error        = in_errors ? 1'b1 : fin_err_reg;
    assign sequence_length = in_errors ? ucpd_pkg::LenOne : fin_len_reg;
    assign last_result     = !in_errors || ((err_left_reg == 2'd1) && !fin_left_reg);

    assign pop   = result_valid && !result_stall;
    assign ready = !result_valid || (pop && last_result);

    // Count down the results still owed for the current request.
    always_comb
    begin
        err_left_next = err_left_reg;
        fin_left_next = fin_left_reg;
        if (load)
        begin
            err_left_next = bundle.err_cnt;
            fin_left_next = bundle.has_final;
        end
        else if (pop)
        begin
            if (in_errors)
            begin
                err_left_next = err_left_reg - 2'd1;
            end
            else
            begin
                fin_left_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_left_reg <= 2'd0;
            fin_left_reg <= 1'b0;
        end
        else
        begin
            err_left_reg <= err_left_next;
            fin_left_reg <= fin_left_next;
        end
    end

    // Final result payload is captured with the bundle.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg      <= bundle.final_cp;
            fin_err_reg <= bundle.final_err;
            fin_len_reg <= bundle.final_len;
        end
    end

endmodule

[verif/utf8_code_point_decoder_top_tb.sv]
module utf8_code_point_decoder_top_tb;

    localparam int MaxCycles  = 200000;
    localparam int TailCycles = 20;
    localparam int RandomBytes = 190;

    // One decoded result as the block should present it.
    typedef struct packed {
        logic [ucpd_pkg::CpW-1:0]  cp;
        logic                      err;
        logic [ucpd_pkg::LenW-1:0] len;
        logic                      fin;
    } code_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          text_valid;
    logic                          text_stall;
    logic [ucpd_pkg::ByteW-1:0]    text_byte;
    logic                          result_valid;
    logic                          result_stall;
    logic [ucpd_pkg::CpW-1:0]      code_point;
    logic                          is_error;
    logic [ucpd_pkg::LenW-1:0]     sequence_length;
    logic                          last_result;

    // Decoder state mirrored by the predictor.
    logic [ucpd_pkg::CpW-1:0]      seq_value;
    logic [ucpd_pkg::LenW-1:0]     seq_total;
    logic [ucpd_pkg::LenW-1:0]     seq_held;

    code_result_t        pending_codes[$];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  bytes_sent = 0;
    bit                  steady = 1'b0;

    utf8_code_point_decoder_top dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_stall      (text_stall),
        .text_byte       (text_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .code_point      (code_point),
        .is_error        (is_error),
        .sequence_length (sequence_length),
        .last_result     (last_result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Works out the results that one text byte causes and queues them in order.
    task automatic decode_byte(input logic [ucpd_pkg::ByteW-1:0] b);
        code_result_t outs[$];
        bit           consumed;
        consumed = 1'b0;
        if (seq_total != ucpd_pkg::LenNone)
        begin
            if (b != '0 && b[7:6] == 2'b10)
            begin
                seq_value = {seq_value[ucpd_pkg::CpW-7:0], b[5:0]};
                seq_held  = seq_held + 3'd1;
                if (seq_held >= seq_total)
                begin
                    outs.push_back('{seq_value, 1'b0, seq_total, 1'b0});
                    seq_value = '0;
                    seq_total = ucpd_pkg::LenNone;
                    seq_held  = ucpd_pkg::LenNone;
                end
                consumed = 1'b1;
            end
            else
            begin
                // Broken sequence: every held byte is reported on its own.
                for (int i = 0; i < int'(seq_held) && i < 4; i++)
                    outs.push_back('{'0, 1'b1, ucpd_pkg::LenOne, 1'b0});
                seq_value = '0;
                seq_total = ucpd_pkg::LenNone;
                seq_held  = ucpd_pkg::LenNone;
            end
        end
        // The current byte is then handled as if no sequence were open.
        if (!consumed && b != '0)
        begin
            if (!b[7])
                outs.push_back('{ucpd_pkg::CpW'(b[6:0]), 1'b0, ucpd_pkg::LenOne, 1'b0});
            else if (!b[6])
                outs.push_back('{'0, 1'b1, ucpd_pkg::LenOne, 1'b0});
            else if (!b[5])
            begin
                seq_value = ucpd_pkg::CpW'(b[4:0]);
                seq_total = ucpd_pkg::LenTwo;
                seq_held  = ucpd_pkg::LenOne;
            end
            else if (!b[4])
            begin
                seq_value = ucpd_pkg::CpW'(b[3:0]);
                seq_total = ucpd_pkg::LenThree;
                seq_held  = ucpd_pkg::LenOne;
            end
            else if (!b[3])
            begin
                seq_value = ucpd_pkg::CpW'(b[2:0]);
                seq_total = ucpd_pkg::LenFour;
                seq_held  = ucpd_pkg::LenOne;
            end
            else
                outs.push_back('{'0, 1'b1, ucpd_pkg::LenOne, 1'b0});
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].fin = 1'b1;
        foreach (outs[i])
            pending_codes.push_back(outs[i]);
    endtask

    // Sends one byte request; valid stays high afterwards unless a gap follows.
    task automatic send_byte(input logic [ucpd_pkg::ByteW-1:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        decode_byte(b);
        text_valid <= 1'b1;
        text_byte  <= b;
        do
            @(posedge clk);
        while (text_stall);
        bytes_sent++;
    endtask

    task automatic send_bytes(input logic [ucpd_pkg::ByteW-1:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Holds off new requests until every queued result has been taken.
    task automatic wait_drained();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_codes.size() != 0);
    endtask

    // Sends one character with random payload bits, optionally cut short.
    task automatic send_char(input bit truncate);
        logic [ucpd_pkg::CpW-1:0]   v;
        logic [ucpd_pkg::ByteW-1:0] seq_bytes[4];
        int                         total;
        v = ucpd_pkg::CpW'($urandom);
        total = $urandom_range(1, 4);
        seq_bytes[1] = {2'b10, v[5:0]};
        seq_bytes[2] = {2'b10, v[5:0]};
        seq_bytes[3] = {2'b10, v[5:0]};
        case (total)
            1: seq_bytes[0] = {1'b0, v[6:0]};
            2: seq_bytes[0] = {3'b110, v[10:6]};
            3:
            begin
                seq_bytes[0] = {4'b1110, v[15:12]};
                seq_bytes[1] = {2'b10, v[11:6]};
            end
            default:
            begin
                seq_bytes[0] = {5'b11110, v[20:18]};
                seq_bytes[1] = {2'b10, v[17:12]};
                seq_bytes[2] = {2'b10, v[11:6]};
            end
        endcase
        if (truncate && total > 1)
            total = $urandom_range(1, total - 1);
        for (int i = 0; i < total; i++)
            send_byte(seq_bytes[i]);
    endtask

    // ASCII extremes, stray continuations, bad leads and a lone terminator.
    task automatic test_single_bytes();
        send_bytes('{8'h7F, 8'h01, 8'h80, 8'hBF, 8'hF8, 8'hFF, 8'h00});
    endtask

    // Well-formed two-, three- and four-byte characters, the widest included.
    task automatic test_complete_sequences();
        send_bytes('{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
    endtask

    // Bad continuation, a lead in place of a continuation, a three-deep flush
    // ahead of a bad lead, and a terminator in the middle of a character.
    task automatic test_broken_sequences();
        send_bytes('{8'hE2, 8'h41, 8'hC3, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'hFF,
                     8'hC2, 8'h00});
    endtask

    // Mostly valid text with random content, plus cut sequences and noise.
    task automatic test_random_text();
        int start;
        int pick;
        bit paused;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < RandomBytes)
        begin
            if ((bytes_sent - start) % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (!paused && bytes_sent - start >= RandomBytes / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_char(1'b0);
            else if (pick < 85)
                send_char(1'b1);
            else if (pick < 95)
                send_byte(ucpd_pkg::ByteW'($urandom));
            else
                send_byte('0);
        end
        steady = 1'b0;
    endtask

    // Result side stalls a random number of cycles before each result.
    initial
    begin
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            int hold;
            hold = draw_wait();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && result_valid));
        end
    end

    // Each accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MaxCycles)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_codes.size() == 0)
                report_mismatch($sformatf("unexpected result cp=%h err=%b len=%0d fin=%b",
                                          code_point, is_error, sequence_length,
                                          last_result));
            else
            begin
                code_result_t want;
                want = pending_codes.pop_front();
                if (code_point !== want.cp)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              code_point, want.cp));
                if (is_error !== want.err)
                    report_mismatch($sformatf("is_error %b, expected %b",
                                              is_error, want.err));
                if (sequence_length !== want.len)
                    report_mismatch($sformatf("sequence_length %0d, expected %0d",
                                              sequence_length, want.len));
                if (last_result !== want.fin)
                    report_mismatch($sformatf("last_result %b, expected %b",
                                              last_result, want.fin));
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        text_valid <= 1'b0;
        text_byte  <= '0;
        seq_value  = '0;
        seq_total  = ucpd_pkg::LenNone;
        seq_held   = ucpd_pkg::LenNone;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_complete_sequences();
        test_broken_sequences();
        test_random_text();

        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (pending_codes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_codes.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
